/* rtl/sdbp_pkg.sv */
// Shared constants, types and register indexes for the saturating delta bit packer.
// No dependencies; every other file in rtl/ imports this package.
package sdbp_pkg;

  localparam int DELTA_BITS        = 2;
  localparam int FRAME_BYTES       = 90;
  localparam int CHANNELS          = 4;
  localparam int VAL_W             = 32;
  localparam int SCALE_W           = 16;
  localparam int CFG_IDX_W         = 8;
  localparam int SAMPLE_BITS       = CHANNELS * DELTA_BITS;
  localparam int SAMPLES_PER_FRAME = (FRAME_BYTES * 8) / SAMPLE_BITS;
  localparam int FRAME_BITS        = SAMPLES_PER_FRAME * SAMPLE_BITS;
  // bytes one sample can produce: leftover partial bits plus the new codes, plus a flush
  localparam int ACC_BYTES         = (SAMPLE_BITS + 14) / 8;
  localparam int ACC_W             = ACC_BYTES * 8;
  localparam int POS_W             = $clog2(FRAME_BITS + SAMPLE_BITS + 1);
  localparam int CNT_W             = $clog2(ACC_BYTES + 1);
  localparam int TOT_W             = $clog2(SAMPLE_BITS + 8);

  localparam logic signed [VAL_W:0] DELTA_MAX = (VAL_W + 1)'((1 << (DELTA_BITS - 1)) - 1);
  localparam logic signed [VAL_W:0] DELTA_MIN = -DELTA_MAX - (VAL_W + 1)'(1);

  localparam int FRAC_CHANNEL = 2;
  localparam int INIT_CHANNEL = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_CH0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_CH1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_CH2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_CH3 = CFG_IDX_W'(3);

  localparam logic [SCALE_W-1:0] SCALE_RESET [CHANNELS] = '{
    SCALE_W'(1), SCALE_W'(1), SCALE_W'(10), SCALE_W'(1)
  };

  typedef struct packed {
    logic load;       // word enters the multiply stage
    logic load_init;  // that word is an init item
    logic adv;        // multiply stage result moves to the delta stage
    logic adv_init;   // the moving word is an init item
  } lane_ctrl_t;

endpackage

/* rtl/saturating_delta_bit_packer_top.sv */
// An accepted sample word passes the multiply register and the delta code register, then
// enters the merge byte queue, which drives m_tdata. One word per cycle while a sample yields
// at most one byte and m_tready is high; else the queue sends one byte per cycle.
// Reset clears references, frame position, partial byte and queues; scales go to 1,1,10,1.
// Top level: four channel lanes, merge/pack stage, scale registers. Depends on sdbp_pkg,
// sdbp_lane, sdbp_merge.
module saturating_delta_bit_packer_top
  import sdbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // channel0_value[15:0], channel1_value[47:16], channel2_value[79:48], channel3_value[95:80]
  input  logic [95:0]          s_tdata,
  // func (0 sample, 1 init references)
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // packed_byte[7:0]
  output logic [7:0]           m_tdata,
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]   cfg_data
);

  logic [SCALE_W-1:0]      scale [CHANNELS];
  logic signed [VAL_W-1:0] lane_val [CHANNELS];
  logic [VAL_W-1:0]        lane_init [CHANNELS];
  logic [DELTA_BITS-1:0]   lane_code [CHANNELS];
  logic [SAMPLE_BITS-1:0]  codes;
  lane_ctrl_t              lctrl;
  logic                    accept;
  logic                    s1_valid;
  logic                    s1_init;
  logic                    s1_adv;
  logic                    s2_valid;
  logic                    s2_init;
  logic                    mrg_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        scale[i] <= SCALE_RESET[i];
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCALE_CH0: scale[0] <= cfg_data;
        REG_SCALE_CH1: scale[1] <= cfg_data;
        REG_SCALE_CH2: scale[2] <= cfg_data;
        REG_SCALE_CH3: scale[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lane_val[0]  = $signed({{16{s_tdata[15]}}, s_tdata[15:0]});
  assign lane_val[1]  = $signed(s_tdata[47:16]);
  assign lane_val[2]  = $signed(s_tdata[79:48]);
  assign lane_val[3]  = $signed({16'd0, s_tdata[95:80]});
  assign lane_init[0] = '0;
  assign lane_init[1] = '0;
  assign lane_init[2] = '0;
  assign lane_init[3] = {16'd0, s_tdata[95:80]};

  assign s1_adv   = s1_valid && (!s2_valid || mrg_ready);
  assign s_tready = !s1_valid || !s2_valid || mrg_ready;
  assign accept   = s_tvalid && s_tready;

  assign lctrl.load      = accept;
  assign lctrl.load_init = s_tuser;
  assign lctrl.adv       = s1_adv;
  assign lctrl.adv_init  = s1_init;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_valid && mrg_ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_init <= s_tuser;
    end
    if (s1_adv) begin
      s2_init <= s1_init;
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    sdbp_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (lctrl),
      .value    (lane_val[g]),
      .scale    (scale[g]),
      .frac     (g == FRAC_CHANNEL),
      .init_ref ((g == INIT_CHANNEL) ? lane_init[g] : '0),
      .code     (lane_code[g])
    );
    assign codes[g*DELTA_BITS +: DELTA_BITS] = lane_code[g];
  end

  sdbp_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .in_init  (s2_init),
    .codes    (codes),
    .in_ready (mrg_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("multiply stage dropped a stalled word");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !mrg_ready) |=> (s2_valid && $stable(codes)))
    else $error("delta stage changed while stalled");

  a_init_flow: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_init) |=> (s2_valid && s2_init))
    else $error("init word lost between stages");

endmodule

/* rtl/sdbp_lane.sv */
// One channel lane: scale multiply stage, then saturated delta against the tracked reference.
// Depends on sdbp_pkg.
module sdbp_lane
  import sdbp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  lane_ctrl_t              ctrl,
  input  logic signed [VAL_W-1:0] value,
  input  logic [SCALE_W-1:0]      scale,
  input  logic                    frac,
  input  logic [VAL_W-1:0]        init_ref,
  output logic [DELTA_BITS-1:0]   code
);

  logic signed [VAL_W+SCALE_W:0] prod;
  logic [VAL_W-1:0]              mul_out;
  logic [VAL_W-1:0]              scaled;
  logic signed [VAL_W-1:0]       reference;
  logic signed [VAL_W:0]         diff;
  logic signed [VAL_W:0]         dsat;
  logic signed [VAL_W-1:0]       reference_next;

  assign prod = (VAL_W+SCALE_W+1)'(value) * (VAL_W+SCALE_W+1)'($signed({1'b0, scale}));

  // Q16.16: drop 16 fraction bits, truncating toward zero for negative products
  always_comb begin
    if (frac) begin
      mul_out = prod[VAL_W+15:16]
              + VAL_W'(prod[VAL_W+SCALE_W] && (prod[15:0] != 16'd0));
    end else begin
      mul_out = prod[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      scaled <= ctrl.load_init ? init_ref : mul_out;
    end
  end

  always_comb begin
    diff = $signed({scaled[VAL_W-1], scaled}) - $signed({reference[VAL_W-1], reference});
    if (diff > DELTA_MAX) begin
      dsat = DELTA_MAX;
    end else if (diff < DELTA_MIN) begin
      dsat = DELTA_MIN;
    end else begin
      dsat = diff;
    end
    reference_next = reference + dsat[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reference <= '0;
    end else if (ctrl.adv) begin
      reference <= ctrl.adv_init ? $signed(scaled) : reference_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      code <= dsat[DELTA_BITS-1:0];
    end
  end

endmodule

/* rtl/sdbp_merge.sv */
// Merge stage: packs the lane codes into bytes, tracks frame fill, flushes at frame end,
// and queues the bytes of one sample for the output stream. Depends on sdbp_pkg.
module sdbp_merge
  import sdbp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_init,
  input  logic [SAMPLE_BITS-1:0] codes,
  output logic                   in_ready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,
  output logic                   m_tlast
);

  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     pos_sum;
  logic [7:0]           partial;
  logic [7:0]           partial_sel;
  logic [2:0]           off;
  logic [ACC_W-1:0]     acc;
  logic [TOT_W-1:0]     total;
  logic [TOT_W-4:0]     full;
  logic                 frame_end;
  logic [CNT_W-1:0]     count;
  logic [ACC_BYTES-1:0] last_vec;
  logic [7:0]           pend_bytes [ACC_BYTES];
  logic [ACC_BYTES-1:0] pend_last;
  logic [CNT_W-1:0]     pend_cnt;
  logic                 take;

  assign in_ready = (pend_cnt == '0) || ((pend_cnt == CNT_W'(1)) && m_tready);
  assign take     = in_valid && in_ready;
  assign m_tvalid = (pend_cnt != '0);
  assign m_tdata  = pend_bytes[0];
  assign m_tlast  = pend_last[0];

  always_comb begin
    off       = pos[2:0];
    acc       = (ACC_W'(codes) << off) | ACC_W'(partial);
    total     = TOT_W'(off) + TOT_W'(SAMPLE_BITS);
    full      = total[TOT_W-1:3];
    pos_sum   = pos + POS_W'(SAMPLE_BITS);
    frame_end = (pos_sum >= POS_W'(FRAME_BITS));
    count     = CNT_W'(full) + CNT_W'(frame_end && (total[2:0] != 3'd0));
    partial_sel = 8'd0;
    for (int i = 0; i < ACC_BYTES; i++) begin
      if (TOT_W'(full) == TOT_W'(i)) begin
        partial_sel = acc[8*i +: 8];
      end
      last_vec[i] = frame_end && (CNT_W'(i + 1) == count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      partial <= '0;
    end else if (take && !in_init) begin
      pos     <= frame_end ? '0 : pos_sum;
      partial <= frame_end ? 8'd0 : partial_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= '0;
    end else if (take) begin
      pend_cnt <= in_init ? '0 : count;
    end else if (m_tvalid && m_tready) begin
      pend_cnt <= pend_cnt - CNT_W'(1);
    end
  end

  // byte queue of one sample; head byte drives the output
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < ACC_BYTES; i++) begin
        pend_bytes[i] <= acc[8*i +: 8];
      end
      pend_last <= last_vec;
    end else if (m_tvalid && m_tready) begin
      for (int i = 0; i < ACC_BYTES - 1; i++) begin
        pend_bytes[i] <= pend_bytes[i+1];
      end
      pend_last <= pend_last >> 1;
    end
  end

endmodule

/* dv/saturating_delta_bit_packer_top_test.sv */
// Self-checking test of saturating_delta_bit_packer_top: directed and random sample words,
// scale register sweeps and output back-pressure, checked against an in-bench delta encoder.
// Depends on sdbp_pkg and the saturating_delta_bit_packer_top RTL.
module saturating_delta_bit_packer_top_test;
  import sdbp_pkg::*;

  typedef enum logic {FUNC_SAMPLE = 1'b0, FUNC_INIT = 1'b1} func_e;

  typedef struct {
    func_e              func;
    logic signed [15:0] ch0;
    logic signed [31:0] ch1;
    logic signed [31:0] ch2;  // Q16.16
    logic [15:0]        ch3;
  } sample_word_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } out_byte_t;

  localparam longint D_MAX = longint'((1 << (DELTA_BITS - 1)) - 1);
  localparam longint D_MIN = -longint'(1 << (DELTA_BITS - 1));
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = '1;
  localparam logic [CFG_IDX_W-1:0] SCALE_REGS [CHANNELS] = '{
    REG_SCALE_CH0, REG_SCALE_CH1, REG_SCALE_CH2, REG_SCALE_CH3
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [95:0]          s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SCALE_W-1:0]   cfg_data = '0;

  saturating_delta_bit_packer_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // encoder state, updated on accepted words
  int                 track_ref [CHANNELS];
  int                 bit_pos;
  logic [7:0]         fill_byte = '0;
  logic [SCALE_W-1:0] pred_scale [CHANNELS] = SCALE_RESET;
  out_byte_t          pending_bytes [$];

  // stimulus side
  int                 walk [CHANNELS];
  logic [SCALE_W-1:0] scale_setting [CHANNELS] = SCALE_RESET;
  bit                 idle_enable = 1'b1;
  bit                 hold_requested = 1'b0;
  int                 rx_stall;
  int                 error_count;
  int                 idle_cycles;

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void encode_sample(input sample_word_t w);
    longint raw [CHANNELS];
    longint diff;
    int     scaled;
    int     emitted;
    emitted = 0;
    if (w.func == FUNC_INIT) begin
      for (int ch = 0; ch < CHANNELS; ch++) track_ref[ch] = 0;
      track_ref[INIT_CHANNEL] = int'({16'd0, w.ch3});
      return;
    end
    raw[0] = longint'(w.ch0) * longint'(pred_scale[0]);
    raw[1] = longint'(w.ch1) * longint'(pred_scale[1]);
    // Q16.16 product, signed division truncates toward zero
    raw[FRAC_CHANNEL] = (longint'(w.ch2) * longint'(pred_scale[FRAC_CHANNEL])) / 65536;
    raw[INIT_CHANNEL] = longint'(w.ch3) * longint'(pred_scale[INIT_CHANNEL]);
    for (int ch = 0; ch < CHANNELS; ch++) begin
      scaled = int'(raw[ch]);
      diff = longint'(scaled) - longint'(track_ref[ch]);
      if (diff > D_MAX) diff = D_MAX;
      if (diff < D_MIN) diff = D_MIN;
      track_ref[ch] = int'(longint'(track_ref[ch]) + diff);
      for (int b = 0; b < DELTA_BITS; b++) begin
        fill_byte[bit_pos % 8] = diff[b];
        bit_pos++;
        if (bit_pos % 8 == 0) begin
          pending_bytes.push_back('{fill_byte, 1'b0});
          fill_byte = '0;
          emitted++;
        end
      end
    end
    if (bit_pos >= FRAME_BITS) begin
      if (bit_pos % 8 != 0) begin
        pending_bytes.push_back('{fill_byte, 1'b0});
        fill_byte = '0;
        emitted++;
      end
      if (emitted > 0) pending_bytes[pending_bytes.size() - 1].last = 1'b1;
      bit_pos = 0;
    end
  endfunction

  // observes all three channels at each edge; also the watchdog
  always @(posedge clk) begin
    sample_word_t w;
    out_byte_t    exp_byte;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCALE_CH0: pred_scale[0] = cfg_data;
          REG_SCALE_CH1: pred_scale[1] = cfg_data;
          REG_SCALE_CH2: pred_scale[2] = cfg_data;
          REG_SCALE_CH3: pred_scale[3] = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        w.func = func_e'(s_tuser);
        w.ch0  = s_tdata[15:0];
        w.ch1  = s_tdata[47:16];
        w.ch2  = s_tdata[79:48];
        w.ch3  = s_tdata[95:80];
        encode_sample(w);
      end
      if (m_tvalid && m_tready) begin
        if (pending_bytes.size() == 0) begin
          note_error($sformatf("unexpected byte: data %02h last %0b", m_tdata, m_tlast));
        end else begin
          exp_byte = pending_bytes.pop_front();
          if (m_tdata !== exp_byte.data || m_tlast !== exp_byte.last)
            note_error($sformatf("byte mismatch: expected data %02h last %0b, got %02h last %0b",
                                 exp_byte.data, exp_byte.last, m_tdata, m_tlast));
        end
      end
      if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("saturating_delta_bit_packer_top_test: errors");
        $finish;
      end
    end
  end

  // output side: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (hold_requested) begin
      rx_stall = HOLD_CYCLES;
      hold_requested = 1'b0;
    end
    if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall--;
    end else begin
      m_tready <= 1'b1;
      if (idle_enable) rx_stall = pick_gap();
    end
  end

  function automatic sample_word_t make_word(input func_e func, input logic [15:0] c0,
                                             input logic [31:0] c1, input logic [31:0] c2,
                                             input logic [15:0] c3);
    sample_word_t w;
    w.func = func;
    w.ch0  = c0;
    w.ch1  = c1;
    w.ch2  = c2;
    w.ch3  = c3;
    return w;
  endfunction

  // value whose scaled form lands near target t
  function automatic logic [31:0] near_value(input int t, input logic [SCALE_W-1:0] s,
                                             input bit frac);
    if (s == 0) return $urandom;
    if (frac) return 32'((longint'(t) * 65536) / longint'(s)
                         + longint'($urandom_range(0, 255)));
    return 32'(longint'(t) / longint'(s));
  endfunction

  function automatic sample_word_t random_word();
    sample_word_t w;
    int pick;
    pick = $urandom_range(0, 19);
    for (int ch = 0; ch < CHANNELS; ch++) walk[ch] += int'($urandom_range(0, 4)) - 2;
    w = make_word(FUNC_SAMPLE, 16'($urandom), $urandom, $urandom, 16'($urandom));
    if (pick == 0) begin
      w.func = FUNC_INIT;
      for (int ch = 0; ch < CHANNELS; ch++) walk[ch] = 0;
      walk[INIT_CHANNEL] = int'({16'd0, w.ch3});
    end else if (pick >= 7) begin
      // mostly small deltas so every code shows up, not just the rails
      w.ch0 = 16'(near_value(walk[0], scale_setting[0], 1'b0));
      w.ch1 = near_value(walk[1], scale_setting[1], 1'b0);
      w.ch2 = near_value(walk[FRAC_CHANNEL], scale_setting[FRAC_CHANNEL], 1'b1);
      w.ch3 = 16'(near_value(walk[INIT_CHANNEL], scale_setting[INIT_CHANNEL], 1'b0));
    end
    return w;
  endfunction

  task automatic send_word(input sample_word_t w);
    int gap;
    gap = idle_enable ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= w.func;
    s_tdata  <= {w.ch3, w.ch2, w.ch1, w.ch0};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // block must be idle; cfg_valid stays high across back-to-back writes
  task automatic program_scales(input logic [SCALE_W-1:0] s0, input logic [SCALE_W-1:0] s1,
                                input logic [SCALE_W-1:0] s2, input logic [SCALE_W-1:0] s3,
                                input bit stray_write);
    logic [SCALE_W-1:0] vals [CHANNELS];
    vals = '{s0, s1, s2, s3};
    for (int ch = 0; ch < CHANNELS; ch++) begin
      cfg_valid <= 1'b1;
      cfg_index <= SCALE_REGS[ch];
      cfg_data  <= vals[ch];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      scale_setting[ch] = vals[ch];
    end
    if (stray_write) begin
      cfg_index <= REG_NONE;
      cfg_data  <= 16'($urandom);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_word(random_word());
  endtask

  task automatic test_directed_extremes();
    send_word(make_word(FUNC_SAMPLE, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000));
    send_word(make_word(FUNC_SAMPLE, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF));
    send_word(make_word(FUNC_SAMPLE, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF));
    send_word(make_word(FUNC_SAMPLE, 16'h8000, 32'h8000_0000, 32'h8000_0000, 16'h0000));
    // init ignores channels 0..2, loads channel 3 unscaled
    send_word(make_word(FUNC_INIT, 16'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_word(make_word(FUNC_SAMPLE, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFF));
    send_word(make_word(FUNC_SAMPLE, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFE));
    send_word(make_word(FUNC_INIT, 16'h8000, 32'h8000_0000, 32'h8000_0000, 16'h0000));
    send_word(make_word(FUNC_INIT, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000));
    // fractional channel: small negatives truncate to zero, not to -1
    send_word(make_word(FUNC_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001));
    send_word(make_word(FUNC_SAMPLE, 16'h0000, 32'h0000_0000, -32'sd6554, 16'h0000));
    send_word(make_word(FUNC_SAMPLE, 16'h0000, 32'h0000_0000, 32'sd6554, 16'h0000));
    send_word(make_word(FUNC_SAMPLE, 16'h0000, 32'h0000_0000, 32'sd6553, 16'h0000));
    drain();
  endtask

  task automatic test_wrap_extremes();
    program_scales(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_word(make_word(FUNC_INIT, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000));
    send_word(make_word(FUNC_SAMPLE, 16'h8000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF));
    send_word(make_word(FUNC_SAMPLE, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF));
    send_word(make_word(FUNC_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000));
    send_word(make_word(FUNC_SAMPLE, 16'h0001, 32'h0000_0001, 32'h0000_0001, 16'h0001));
    drain();
  endtask

  task automatic test_random_traffic();
    program_scales(SCALE_RESET[0], SCALE_RESET[1], SCALE_RESET[2], SCALE_RESET[3], 1'b0);
    send_random(120);
    idle_enable = 1'b0;
    send_random(30);
    idle_enable = 1'b1;
    drain();
  endtask

  task automatic test_scale_settings();
    program_scales(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_random(50);
    drain();
    program_scales(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_random(50);
    drain();
    program_scales(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    send_random(50);
    drain();
    program_scales(16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
    send_random(50);
    drain();
  endtask

  // long output hold while words keep coming, so the input side backs up
  task automatic test_backpressure();
    idle_enable = 1'b0;
    hold_requested = 1'b1;
    send_random(70);
    idle_enable = 1'b1;
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_wrap_extremes();
    test_random_traffic();
    test_scale_settings();
    test_backpressure();
    if (error_count == 0)
      $display("saturating_delta_bit_packer_top_test: clean");
    else
      $display("saturating_delta_bit_packer_top_test: errors");
    $finish;
  end

endmodule

/* files.f */
rtl/sdbp_pkg.sv
rtl/sdbp_lane.sv
rtl/sdbp_merge.sv
rtl/saturating_delta_bit_packer_top.sv
dv/saturating_delta_bit_packer_top_test.sv
